/* rtl/set_assoc_cache_tag_lookup_unit_assert.svh */
// Assertion macros for the cache tag lookup unit.
// Both expect signals named clk and rst in the module that uses them.
`ifndef SET_ASSOC_CACHE_TAG_LOOKUP_UNIT_ASSERT_SVH
`define SET_ASSOC_CACHE_TAG_LOOKUP_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SACL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SACL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sacl_pkg.sv */
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and constants of the cache tag lookup unit.
// ----------------------------------------------------------------------------
package sacl_pkg;

  localparam int ADDR_W  = 32;
  localparam int TAG_W   = 32;
  localparam int STAMP_W = 32;
  localparam int CNT_W   = 32;
  localparam int DATA_W  = 32;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_OFFSET_WIDTH = 2'd0;
  localparam logic [1:0] REG_INDEX_WIDTH  = 2'd1;
  localparam logic [1:0] REG_WAYS_IN_USE  = 2'd2;
  localparam logic [1:0] REG_REPLACE_FIFO = 2'd3;

  // Register reset values
  localparam logic [3:0] RST_OFFSET_WIDTH = 4'd4;
  localparam logic [2:0] RST_INDEX_WIDTH  = 3'd0;
  localparam logic [3:0] RST_WAYS_IN_USE  = 4'd8;
  localparam logic       RST_REPLACE_FIFO = 1'b1;

  typedef struct packed {
    logic [3:0] offset_width;
    logic [2:0] index_width;
    logic [3:0] ways_in_use;
    logic       replace_fifo;
  } cfg_t;

  // Controller -> datapath
  typedef struct packed {
    logic capture;     // take the address beat, read the set
    logic scan_start;  // clear the victim search
    logic scan_step;   // compare one way's age
    logic commit;      // write the set back, update counters, load result
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic hit;         // valid matching way in the set
    logic free;        // an invalid way in use exists
    logic scan_last;   // search is at the last way in use
    logic out_free;    // result register can take a beat
  } status_t;

endpackage

/* rtl/sacl_ram.sv */
// ----------------------------------------------------------------------------
// sacl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sacl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/sacl_ctrl.sv */
// ----------------------------------------------------------------------------
// sacl_ctrl
// Sequencer: lookup, optional victim search, write-back of one access.
// ----------------------------------------------------------------------------
module sacl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  sacl_pkg::status_t status,
  output sacl_pkg::cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_WRITE  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (status.hit || status.free) begin
          if (status.out_free) begin
            cmd.commit = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* rtl/sacl_dp.sv */
// ----------------------------------------------------------------------------
// sacl_dp
// Address split, set RAM, tag compare, age search, counters, result register.
// ----------------------------------------------------------------------------
module sacl_dp #(
  parameter int WAYS     = 8,
  parameter int SET_BITS = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sacl_pkg::cfg_t                cfg,
  input  logic [sacl_pkg::ADDR_W-1:0]   access_address,
  input  sacl_pkg::cmd_t                cmd,
  output sacl_pkg::status_t             status,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic                          hit,
  output logic [sacl_pkg::CNT_W-1:0]    hit_count,
  output logic [sacl_pkg::CNT_W-1:0]    access_count
);

  localparam int SETS     = 1 << SET_BITS;
  localparam int SET_AW   = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_W    = sacl_pkg::TAG_W;
  localparam int STAMP_W  = sacl_pkg::STAMP_W;
  localparam int STAMP_LO = WAYS * TAG_W;
  localparam int VLD_LO   = WAYS * (TAG_W + STAMP_W);
  localparam int ROW_W    = WAYS * (TAG_W + STAMP_W + 1);

  // Address split
  logic [3:0]                  iw;
  logic [sacl_pkg::ADDR_W-1:0] addr_shift;
  logic [SET_AW-1:0]           set_mask;
  logic [SET_AW-1:0]           set_in;
  logic [4:0]                  tag_shamt;
  logic [TAG_W-1:0]            tag_in;

  always_comb begin
    iw = ({1'b0, cfg.index_width} > 4'(SET_BITS)) ? 4'(SET_BITS)
                                                  : {1'b0, cfg.index_width};
    addr_shift = access_address >> cfg.offset_width;
    for (int b = 0; b < SET_AW; b++) begin
      set_mask[b] = (4'(b) < iw);
    end
    set_in    = addr_shift[SET_AW-1:0] & set_mask;
    tag_shamt = {1'b0, cfg.offset_width} + {1'b0, iw};
    tag_in    = access_address >> tag_shamt;
  end

  logic [SET_AW-1:0] set_q;
  logic [TAG_W-1:0]  tag_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      set_q <= set_in;
      tag_q <= tag_in;
    end
  end

  // Set RAM: one row holds the tags, stamps and valid bits of all ways
  logic [ROW_W-1:0] rdata;
  logic [ROW_W-1:0] wdata;

  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_set_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (set_q),
    .wdata (wdata),
    .re    (cmd.capture),
    .raddr (set_in),
    .rdata (rdata)
  );

  // Per-set written flags: a set never written reads as all invalid
  logic [SETS-1:0] row_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.commit) begin
      row_valid[set_q] <= 1'b1;
    end
  end

  // Row unpack
  logic [TAG_W-1:0]   tags   [WAYS];
  logic [STAMP_W-1:0] stamps [WAYS];
  logic [WAYS-1:0]    row_vld;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      tags[w]   = rdata[w*TAG_W +: TAG_W];
      stamps[w] = rdata[STAMP_LO + w*STAMP_W +: STAMP_W];
    end
    row_vld = row_valid[set_q] ? rdata[VLD_LO +: WAYS] : '0;
  end

  // Ways in use, clamped to 1..WAYS
  logic [4:0] nways;
  logic [4:0] nways_m1;

  always_comb begin
    priority if (cfg.ways_in_use == 4'd0) begin
      nways = 5'd1;
    end else if ({1'b0, cfg.ways_in_use} > 5'(WAYS)) begin
      nways = 5'(WAYS);
    end else begin
      nways = {1'b0, cfg.ways_in_use};
    end
    nways_m1 = nways - 5'd1;
  end

  // Tag compare and free-way search, lowest way first
  logic [WAYS-1:0]  match;
  logic [WAYS-1:0]  free_vec;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] free_way;

  always_comb begin
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      match[w]    = (5'(w) < nways) && row_vld[w] && (tags[w] == tag_q);
      free_vec[w] = (5'(w) < nways) && !row_vld[w];
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
      if (free_vec[w]) begin
        free_way = WAY_W'(w);
      end
    end
  end

  // Counters
  logic [sacl_pkg::CNT_W-1:0] access_total;
  logic [sacl_pkg::CNT_W-1:0] hit_total;
  logic [sacl_pkg::CNT_W-1:0] access_total_next;
  logic [sacl_pkg::CNT_W-1:0] hit_total_next;
  logic                       lookup_hit;

  assign lookup_hit        = |match;
  assign access_total_next = access_total + 1'b1;
  assign hit_total_next    = lookup_hit ? hit_total + 1'b1 : hit_total;

  // Victim search: one way per cycle, largest age wins, lowest way on ties
  logic [WAY_W-1:0]   scan_idx;
  logic [WAY_W-1:0]   victim;
  logic [STAMP_W-1:0] best_age;
  logic [STAMP_W-1:0] age_cur;

  assign age_cur = access_total_next - stamps[scan_idx];

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx <= '0;
    end else if (cmd.scan_step) begin
      if ((scan_idx == '0) || (age_cur > best_age)) begin
        best_age <= age_cur;
        victim   <= scan_idx;
      end
      scan_idx <= scan_idx + 1'b1;
    end
  end

  // Write-back row
  logic [WAY_W-1:0]   sel_way;
  logic [TAG_W-1:0]   wr_tags   [WAYS];
  logic [STAMP_W-1:0] wr_stamps [WAYS];
  logic [WAYS-1:0]    wr_vld;

  always_comb begin
    priority if (lookup_hit) begin
      sel_way = hit_way;
    end else if (|free_vec) begin
      sel_way = free_way;
    end else begin
      sel_way = victim;
    end
    wr_vld = row_vld;
    for (int w = 0; w < WAYS; w++) begin
      wr_tags[w]   = tags[w];
      wr_stamps[w] = stamps[w];
    end
    if (lookup_hit) begin
      if (!cfg.replace_fifo) begin
        wr_stamps[sel_way] = access_total_next;
      end
    end else begin
      wr_tags[sel_way]   = tag_q;
      wr_stamps[sel_way] = access_total_next;
      wr_vld[sel_way]    = 1'b1;
    end
    for (int w = 0; w < WAYS; w++) begin
      wdata[w*TAG_W +: TAG_W]                 = wr_tags[w];
      wdata[STAMP_LO + w*STAMP_W +: STAMP_W] = wr_stamps[w];
    end
    wdata[VLD_LO +: WAYS] = wr_vld;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      access_total <= '0;
      hit_total    <= '0;
    end else if (cmd.commit) begin
      access_total <= access_total_next;
      hit_total    <= hit_total_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit          <= lookup_hit;
      hit_count    <= hit_total_next;
      access_count <= access_total_next;
    end
  end

  // Status
  always_comb begin
    status.hit       = lookup_hit;
    status.free      = |free_vec;
    status.scan_last = (scan_idx == nways_m1[WAY_W-1:0]);
    status.out_free  = !out_valid || !out_stall;
  end

endmodule

/* rtl/set_assoc_cache_tag_lookup_unit.sv */
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup_unit: one address beat in, one result beat out.
// Hit/free-way fill: set read, then commit when the result register has room.
// Full-set miss: age search, one compare per cycle over 1..WAYS ways in use.
// Busy until commit. Reset clears counters, loads defaults, empties all sets.
// ----------------------------------------------------------------------------
`include "set_assoc_cache_tag_lookup_unit_assert.svh"

module set_assoc_cache_tag_lookup_unit #(
  parameter int WAYS     = 8,
  parameter int SET_BITS = 6
) (
  input  logic                               clk,
  input  logic                               rst,
  // address channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [sacl_pkg::ADDR_W-1:0]        access_address,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               hit,
  output logic [sacl_pkg::CNT_W-1:0]         hit_count,
  output logic [sacl_pkg::CNT_W-1:0]         access_count,
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [3:0]                         paddr,
  input  logic [sacl_pkg::DATA_W-1:0]        pwdata,
  output logic [sacl_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);

  sacl_pkg::cfg_t    cfg;
  sacl_pkg::cmd_t    cmd;
  sacl_pkg::status_t status;
  logic              cfg_wr;

  // Register writes
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_width <= sacl_pkg::RST_OFFSET_WIDTH;
      cfg.index_width  <= sacl_pkg::RST_INDEX_WIDTH;
      cfg.ways_in_use  <= sacl_pkg::RST_WAYS_IN_USE;
      cfg.replace_fifo <= sacl_pkg::RST_REPLACE_FIFO;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        sacl_pkg::REG_OFFSET_WIDTH: cfg.offset_width <= pwdata[3:0];
        sacl_pkg::REG_INDEX_WIDTH:  cfg.index_width  <= pwdata[2:0];
        sacl_pkg::REG_WAYS_IN_USE:  cfg.ways_in_use  <= pwdata[3:0];
        sacl_pkg::REG_REPLACE_FIFO: cfg.replace_fifo <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (paddr[3:2])
      sacl_pkg::REG_OFFSET_WIDTH: prdata = {28'd0, cfg.offset_width};
      sacl_pkg::REG_INDEX_WIDTH:  prdata = {29'd0, cfg.index_width};
      sacl_pkg::REG_WAYS_IN_USE:  prdata = {28'd0, cfg.ways_in_use};
      sacl_pkg::REG_REPLACE_FIFO: prdata = {31'd0, cfg.replace_fifo};
      default:                    prdata = '0;
    endcase
  end

  sacl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sacl_dp #(
    .WAYS     (WAYS),
    .SET_BITS (SET_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .access_address (access_address),
    .cmd            (cmd),
    .status         (status),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .hit            (hit),
    .hit_count      (hit_count),
    .access_count   (access_count)
  );

  // Checks
  `SACL_ASSERT_NEXT(a_one_item_in_flight, in_valid && !in_stall, in_stall, "second beat taken while busy")
  `SACL_ASSERT_NOW(a_commit_needs_room, cmd.commit, status.out_free, "result overwrote an unread beat")
  `SACL_ASSERT_NEXT(a_commit_shows_result, cmd.commit, out_valid, "committed result not presented")

endmodule

/* tb/set_assoc_cache_tag_lookup_unit_tb.sv */
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup_unit_tb
// Self-checking bench for the cache tag lookup unit. A short table of
// addresses runs under the reset settings. Several register settings follow,
// the extremes among them, each with random accesses aimed at a few sets and
// a small pool of tags. A built-in cache model predicts hit flag and running
// counts for every accepted address beat, and each result beat is checked
// against it in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_lookup_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_WAYS        = 8;
  localparam int NUM_SET_BITS    = 6;
  localparam int LINES           = (1 << NUM_SET_BITS) * NUM_WAYS;
  localparam int NUM_DIRECTED    = 18;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 185;
  localparam int IDLE_LIMIT      = 5000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int SETTLE_CYCLES   = 4;

  typedef struct packed {
    logic                       hit;
    logic [sacl_pkg::CNT_W-1:0] hits;
    logic [sacl_pkg::CNT_W-1:0] accesses;
  } lookup_res_t;

  typedef struct packed {
    logic [sacl_pkg::ADDR_W-1:0] addr;
    logic                        typed;
    lookup_res_t                 res;
  } access_row_t;

  // DUT signals
  logic                        clk;
  logic                        rst            = 1'b1;
  logic                        in_valid       = 1'b0;
  logic                        in_stall;
  logic [sacl_pkg::ADDR_W-1:0] access_address = '0;
  logic                        out_valid;
  logic                        out_stall      = 1'b0;
  logic                        hit;
  logic [sacl_pkg::CNT_W-1:0]  hit_count;
  logic [sacl_pkg::CNT_W-1:0]  access_count;
  logic                        psel           = 1'b0;
  logic                        penable        = 1'b0;
  logic                        pwrite         = 1'b0;
  logic [3:0]                  paddr          = '0;
  logic [sacl_pkg::DATA_W-1:0] pwdata         = '0;
  logic [sacl_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  set_assoc_cache_tag_lookup_unit uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .access_address (access_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .hit            (hit),
    .hit_count      (hit_count),
    .access_count   (access_count),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Cache model state
  logic [sacl_pkg::TAG_W-1:0]   line_tag   [LINES];
  logic                         line_valid [LINES];
  logic [sacl_pkg::STAMP_W-1:0] line_stamp [LINES];
  logic [sacl_pkg::CNT_W-1:0]   model_hits;
  logic [sacl_pkg::CNT_W-1:0]   model_accesses;
  sacl_pkg::cfg_t               cfg_mirror;

  lookup_res_t pending_lookups [$];
  int          mismatches  = 0;
  int          idle_cycles = 0;
  int          stall_left  = 0;
  bit          quiet       = 1'b0;

  access_row_t    start_rows [NUM_DIRECTED];
  sacl_pkg::cfg_t phase_cfg  [NUM_PHASES];

  // Index bits actually used: saturates at the number of set bits
  function automatic int used_index_bits();
    return (cfg_mirror.index_width > NUM_SET_BITS) ? NUM_SET_BITS
                                                   : int'(cfg_mirror.index_width);
  endfunction

  // Ways actually used: 0 acts as 1, above the array acts as all ways
  function automatic int used_ways();
    if (cfg_mirror.ways_in_use == 0) return 1;
    if (cfg_mirror.ways_in_use > NUM_WAYS) return NUM_WAYS;
    return int'(cfg_mirror.ways_in_use);
  endfunction

  // One lookup: search, fill or evict, update counters
  function automatic lookup_res_t cache_lookup(input logic [sacl_pkg::ADDR_W-1:0] addr);
    int          iw;
    int          nw;
    int          base;
    int          victim;
    bit          found;
    logic [31:0] set_idx;
    logic [31:0] tag;
    logic [31:0] age;
    logic [31:0] best_age;
    lookup_res_t r;
    iw      = used_index_bits();
    nw      = used_ways();
    set_idx = (addr >> cfg_mirror.offset_width) & ((32'd1 << iw) - 32'd1);
    tag     = addr >> (int'(cfg_mirror.offset_width) + iw);
    base    = int'(set_idx) * NUM_WAYS;
    found   = 1'b0;
    model_accesses = model_accesses + 1;
    for (int w = 0; w < nw; w++) begin
      if (!found && line_valid[base + w] && line_tag[base + w] == tag) begin
        found = 1'b1;
        model_hits = model_hits + 1;
        if (!cfg_mirror.replace_fifo) line_stamp[base + w] = model_accesses;
      end
    end
    if (!found) begin
      // lowest free way first, else oldest stamp (lowest way on ties)
      victim = -1;
      for (int w = 0; w < nw; w++) begin
        if (victim < 0 && !line_valid[base + w]) victim = base + w;
      end
      if (victim < 0) begin
        best_age = '0;
        for (int w = 0; w < nw; w++) begin
          age = model_accesses - line_stamp[base + w];
          if (w == 0 || age > best_age) begin
            best_age = age;
            victim   = base + w;
          end
        end
      end
      line_tag[victim]   = tag;
      line_valid[victim] = 1'b1;
      line_stamp[victim] = model_accesses;
    end
    r.hit      = found;
    r.hits     = model_hits;
    r.accesses = model_accesses;
    return r;
  endfunction

  // Random address: mostly a few sets and a small tag pool, some fully random
  function automatic logic [sacl_pkg::ADDR_W-1:0] pick_address();
    int          iw;
    int          off;
    int          nsets;
    int          span;
    logic [31:0] set_idx;
    logic [31:0] tag;
    logic [31:0] low;
    if ($urandom_range(0, 99) < 20) return $urandom();
    iw      = used_index_bits();
    off     = int'(cfg_mirror.offset_width);
    nsets   = 1 << iw;
    span    = (nsets < 4) ? nsets : 4;
    set_idx = $urandom_range(0, span - 1);
    if ($urandom_range(0, 1)) set_idx = nsets - 1 - set_idx;
    tag = $urandom_range(0, used_ways() + 1);
    if ($urandom_range(0, 1)) tag = ~tag;
    low = $urandom() & ((32'd1 << off) - 32'd1);
    return (tag << (off + iw)) | (set_idx << off) | low;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int pick_idle();
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Send one address beat; the model runs when it is accepted
  task automatic send_access(input logic [sacl_pkg::ADDR_W-1:0] addr, input logic typed,
                             input lookup_res_t typed_res);
    int          gap;
    lookup_res_t predicted;
    gap = pick_idle();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    access_address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = cache_lookup(addr);
    pending_lookups.insert(pending_lookups.size(), typed ? typed_res : predicted);
  endtask

  // Stop sending and wait for every pending result
  task automatic drain_results(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Register write: setup phase, then access phase until pready, then idle
  task automatic write_reg(input logic [1:0] idx, input logic [sacl_pkg::DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    unique case (idx)
      sacl_pkg::REG_OFFSET_WIDTH: cfg_mirror.offset_width = data[3:0];
      sacl_pkg::REG_INDEX_WIDTH:  cfg_mirror.index_width  = data[2:0];
      sacl_pkg::REG_WAYS_IN_USE:  cfg_mirror.ways_in_use  = data[3:0];
      sacl_pkg::REG_REPLACE_FIFO: cfg_mirror.replace_fifo = data[0];
      default: ;
    endcase
  endtask

  // Compare one result beat with the oldest prediction
  task automatic check_result();
    lookup_res_t want;
    if (pending_lookups.size() == 0) begin
      $error("unexpected result beat: hit=%0d hit_count=%0d access_count=%0d",
             hit, hit_count, access_count);
      mismatches++;
      return;
    end
    want = pending_lookups.pop_front();
    if (hit !== want.hit) begin
      $error("hit: expected %0d, got %0d", want.hit, hit);
      mismatches++;
    end
    if (hit_count !== want.hits) begin
      $error("hit_count: expected %0d, got %0d", want.hits, hit_count);
      mismatches++;
    end
    if (access_count !== want.accesses) begin
      $error("access_count: expected %0d, got %0d", want.accesses, access_count);
      mismatches++;
    end
  endtask

  // Result side: check accepted beats, stall in random bursts
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!quiet && $urandom_range(0, 99) < 25) begin
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                   : $urandom_range(1, 3);
        end
      end
    end
  end

  // Watchdog: too long with no beat on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    // reset settings: offset 4, fully associative, 8 ways, FIFO
    start_rows = '{
      '{32'h0000_0000, 1'b1, '{1'b0, 32'd0, 32'd1}},  // cold miss
      '{32'h0000_000F, 1'b1, '{1'b1, 32'd1, 32'd2}},  // same line, top offset
      '{32'hFFFF_FFFF, 1'b1, '{1'b0, 32'd1, 32'd3}},  // all ones
      '{32'hFFFF_FFF0, 1'b1, '{1'b1, 32'd2, 32'd4}},
      '{32'h0000_0010, 1'b0, '0},                      // fill remaining ways
      '{32'h0000_0020, 1'b0, '0},
      '{32'h0000_0030, 1'b0, '0},
      '{32'h0000_0040, 1'b0, '0},
      '{32'h0000_0050, 1'b0, '0},
      '{32'h0000_0060, 1'b0, '0},
      '{32'h0000_0070, 1'b0, '0},                      // full set: evict oldest
      '{32'h0000_0000, 1'b0, '0},                      // evicted line misses
      '{32'h0000_0018, 1'b0, '0},
      '{32'hFFFF_FFF5, 1'b0, '0},
      '{32'h8000_0000, 1'b0, '0},
      '{32'h7FFF_FFFF, 1'b0, '0},
      '{32'hAAAA_AAAA, 1'b0, '0},
      '{32'h5555_5555, 1'b0, '0}
    };
    // offset, index, ways, fifo
    phase_cfg = '{
      '{4'd4,  3'd0, 4'd8,  1'b0},  // LRU, fully associative
      '{4'd0,  3'd6, 4'd1,  1'b0},  // direct mapped, all sets, no offset
      '{4'd12, 3'd7, 4'd4,  1'b1},  // index beyond sets saturates
      '{4'd15, 3'd3, 4'd0,  1'b0},  // widest offset, zero ways acts as one
      '{4'd2,  3'd2, 4'd15, 1'b0},  // ways beyond array act as all
      '{4'd5,  3'd1, 4'd3,  1'b1},
      '{4'd0,  3'd0, 4'd8,  1'b1},
      '{4'd4,  3'd6, 4'd9,  1'b0}
    };

    // model reset
    cfg_mirror.offset_width = sacl_pkg::RST_OFFSET_WIDTH;
    cfg_mirror.index_width  = sacl_pkg::RST_INDEX_WIDTH;
    cfg_mirror.ways_in_use  = sacl_pkg::RST_WAYS_IN_USE;
    cfg_mirror.replace_fifo = sacl_pkg::RST_REPLACE_FIFO;
    model_hits     = '0;
    model_accesses = '0;
    for (int i = 0; i < LINES; i++) begin
      line_valid[i] = 1'b0;
      line_tag[i]   = '0;
      line_stamp[i] = '0;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table under reset settings
    foreach (start_rows[i]) begin
      send_access(start_rows[i].addr, start_rows[i].typed, start_rows[i].res);
    end

    // random phases; lines stay across setting changes
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results(SETTLE_CYCLES);
      write_reg(sacl_pkg::REG_OFFSET_WIDTH, {28'd0, phase_cfg[p].offset_width});
      write_reg(sacl_pkg::REG_INDEX_WIDTH,  {29'd0, phase_cfg[p].index_width});
      write_reg(sacl_pkg::REG_WAYS_IN_USE,  {28'd0, phase_cfg[p].ways_in_use});
      write_reg(sacl_pkg::REG_REPLACE_FIFO, {31'd0, phase_cfg[p].replace_fifo});
      quiet = (p % 3 == 2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_access(pick_address(), 1'b0, '0);
      end
    end

    drain_results(DRAIN_CYCLES);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
